[hdl/hamming_word_decoder_macros.svh]
// ---------------------------------------------------------------------------
// hamming_word_decoder_macros : assertion macros for the word decoder checks
// Concurrent assertion forms, sampled on i_clk, that report through $error.
// ---------------------------------------------------------------------------
`ifndef HAMMING_WORD_DECODER_MACROS_SVH
`define HAMMING_WORD_DECODER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define HWD_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define HWD_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define HWD_CHECK_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/hwd_pkg.sv]
// ---------------------------------------------------------------------------
// hwd_pkg : shared types and constants of the Hamming word decoder
// Field widths, parity check masks and the decode/count control structures.
// ---------------------------------------------------------------------------
package hwd_pkg;

    localparam int unsigned CODE_W  = 32;
    localparam int unsigned DATA_W  = 26;
    localparam int unsigned SYN_W   = 5;
    localparam int unsigned COUNT_W = 16;

    // Bits covered by each syndrome check, lowest check first.
    localparam logic [CODE_W-1:0] CHECK_MASK [SYN_W] = '{
        32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
    };

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic [SYN_W-1:0]  syndrome;
        logic              corrected;
    } t_dec_result;

    typedef struct packed {
        logic update;   // a word moves into the result register
        logic clear;    // clear the count before this word
        logic fixed;    // this word had a bit flipped
    } t_cnt_ctrl;

endpackage

[hdl/hwd_correct.sv]
// ---------------------------------------------------------------------------
// hwd_correct : syndrome, single bit correction and data extraction
// Purely combinational; sits between the input and result registers.
// ---------------------------------------------------------------------------
module hwd_correct (
    input  logic [hwd_pkg::CODE_W-1:0] i_code_word,
    output hwd_pkg::t_dec_result       o_result
);

    logic [hwd_pkg::SYN_W-1:0]  syn;
    logic                       overall;
    logic                       syn_hit;
    logic [hwd_pkg::CODE_W-1:0] flip;
    logic [hwd_pkg::CODE_W-1:0] fixed_word;

    always_comb begin
        for (int k = 0; k < hwd_pkg::SYN_W; k++) begin
            syn[k] = ^(i_code_word & hwd_pkg::CHECK_MASK[k]);
        end
    end

    assign overall = ^i_code_word;
    assign syn_hit = |syn;

    // Nonzero syndrome names the bad bit; otherwise only the overall parity bit, and only if parity is odd.
    assign flip = syn_hit ? (hwd_pkg::CODE_W'(1) << syn)
                          : {{(hwd_pkg::CODE_W-1){1'b0}}, overall};

    assign fixed_word = i_code_word ^ flip;

    assign o_result.data_word = {fixed_word[31:17], fixed_word[15:9],
                                 fixed_word[7:5], fixed_word[3]};
    assign o_result.syndrome  = syn;
    assign o_result.corrected = syn_hit | overall;

endmodule

[hdl/hwd_counter.sv]
// ---------------------------------------------------------------------------
// hwd_counter : saturating count of corrected words
// Clear takes effect before the word that carries it is counted.
// ---------------------------------------------------------------------------
module hwd_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hwd_pkg::t_cnt_ctrl          i_ctrl,
    output logic [hwd_pkg::COUNT_W-1:0] o_next_count
);

    logic [hwd_pkg::COUNT_W-1:0] r_count;
    logic [hwd_pkg::COUNT_W-1:0] base;

    assign base = i_ctrl.clear ? '0 : r_count;

    always_comb begin
        o_next_count = base;
        if (i_ctrl.fixed && (base != hwd_pkg::COUNT_MAX)) begin
            o_next_count = base + hwd_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.update) begin
            r_count <= o_next_count;
        end
    end

endmodule

[hdl/hamming_word_decoder.sv]
// ---------------------------------------------------------------------------
// hamming_word_decoder : single-error-correcting decoder, 32-bit code words
// Two-register pipeline: input register, combinational decode, result register.
// ---------------------------------------------------------------------------
// Decodes one 32-bit Hamming(31,26) code word per request, with an extra
// overall parity bit at index 0. Five parity checks form the syndrome; a
// nonzero syndrome flips the bit it names, a zero syndrome with odd overall
// parity flips bit 0. Double errors are decoded as a single error at the
// syndrome index and are not flagged. The 26 data bits (indices 3, 5-7,
// 9-15, 17-31) come out packed from the lowest index up, together with the
// syndrome, a corrected flag and a saturating (65535) count of corrections.
// A set clear flag zeroes the count before its own word is counted.
// Rate: one request per cycle while the output is not stalled; a request
// passes the input register, then the result register, where its result
// is valid. A request is taken whenever the input register is empty or
// moves on in the same cycle, so one request can be held while a finished
// result waits downstream; the logic between the two registers is the
// parity trees, the bit flip and the count increment.
// ---------------------------------------------------------------------------
module hamming_word_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] code_word
    input  logic        i_s_tuser,   // [0] clear_count
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [25:0] data_word, [30:26] syndrome,
                                     // [46:31] error_count, [47] zero fill
    output logic        o_m_tuser    // [0] corrected
);

    // input register
    logic                        r_in_valid;
    logic [hwd_pkg::CODE_W-1:0]  r_in_code;
    logic                        r_in_clear;

    // result register
    logic                        r_out_valid;
    hwd_pkg::t_dec_result        r_out_res;
    logic [hwd_pkg::COUNT_W-1:0] r_out_count;

    hwd_pkg::t_dec_result        dec_res;
    hwd_pkg::t_cnt_ctrl          cnt_ctrl;
    logic [hwd_pkg::COUNT_W-1:0] next_count;
    logic                        out_free;
    logic                        adv;
    logic                        take;

    // Result slot free when empty or being drained this cycle.
    assign out_free   = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || out_free;
    assign take       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_code  <= i_s_tdata;
            r_in_clear <= i_s_tuser;
        end
    end

    hwd_correct u_correct (
        .i_code_word (r_in_code),
        .o_result    (dec_res)
    );

    // Count moves in step with the word entering the result register, so
    // counts stay in request order whatever the stalls.
    assign cnt_ctrl.update = adv;
    assign cnt_ctrl.clear  = r_in_clear;
    assign cnt_ctrl.fixed  = dec_res.corrected;

    hwd_counter u_counter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (cnt_ctrl),
        .o_next_count (next_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_res   <= dec_res;
            r_out_count <= next_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_res.syndrome, r_out_res.data_word};
    assign o_m_tuser  = r_out_res.corrected;

endmodule

[hdl/hwd_checker.sv]
// ---------------------------------------------------------------------------
// hwd_checker : port-level checks of the Hamming word decoder
// Watches the top level's ports only; bound to every decoder instance.
// ---------------------------------------------------------------------------
`include "hamming_word_decoder_macros.svh"

module hwd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    // Result must not be withdrawn while stalled.
    `HWD_CHECK_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped")

    // A nonzero syndrome always means a flipped bit.
    `HWD_CHECK(a_syn_flag, o_m_tvalid && !o_m_tuser, o_m_tdata[30:26] == 5'd0, "stray syndrome")

    // A corrected word is always counted, so the count cannot read zero.
    `HWD_CHECK(a_count_nz, o_m_tvalid && o_m_tuser, o_m_tdata[46:31] != 16'd0, "not counted")

    // With the result slot empty the input side is always open.
    `HWD_CHECK(a_ready_free, !o_m_tvalid, o_s_tready, "input blocked with result slot empty")

    // No result straight out of reset.
    `HWD_CHECK_RESET(a_rst_idle, !i_rst_n, !o_m_tvalid, "result valid after reset")

endmodule

bind hamming_word_decoder hwd_checker u_hwd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
